// ----- rtl/sspt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted sparse polynomial table package
// Shared widths, codes and types of the term table and its cell row.
// ----------------------------------------------------------------------------
package sspt_pkg;

  localparam int unsigned KindW      = 2;
  localparam int unsigned ExpW       = 16;
  localparam int unsigned CoefW      = 32;
  localparam int unsigned PosW       = 6;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned TermCountW = 7;

  localparam int unsigned MaxTermsDefault = 32;
  localparam int unsigned ExpBitsDefault  = 16;

  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  typedef enum logic [KindW-1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_READ = 2'd2
  } sspt_kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_SAT   = 2'd3
  } sspt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } sspt_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_MERGE
  } sspt_cell_op_e;

  typedef struct packed {
    logic eq;
    logic gt;
    logic sat;
  } sspt_cell_flags_t;

endpackage

// ----- rtl/sspt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Term cell
// Holds one term, compares it with the broadcast term and loads, merges or
// takes the term of a neighbor.
// ----------------------------------------------------------------------------
module sspt_cell #(
  parameter int unsigned EXP_BITS = sspt_pkg::ExpBitsDefault
) (
  input  logic                                clk_i,
  input  sspt_pkg::sspt_cell_op_e             op_i,
  input  logic [EXP_BITS-1:0]                 new_exp_i,
  input  logic signed [sspt_pkg::CoefW-1:0]   new_coef_i,
  input  logic [EXP_BITS-1:0]                 left_exp_i,
  input  logic signed [sspt_pkg::CoefW-1:0]   left_coef_i,
  input  logic [EXP_BITS-1:0]                 right_exp_i,
  input  logic signed [sspt_pkg::CoefW-1:0]   right_coef_i,
  output logic [EXP_BITS-1:0]                 exp_o,
  output logic signed [sspt_pkg::CoefW-1:0]   coef_o,
  output sspt_pkg::sspt_cell_flags_t          flags_o
);
  import sspt_pkg::*;

  logic [EXP_BITS-1:0]      exp_q, exp_d;
  logic signed [CoefW-1:0]  coef_q, coef_d;
  logic signed [CoefW:0]    sum;
  logic                     sat;
  logic signed [CoefW-1:0]  merged;

  assign sum    = {coef_q[CoefW-1], coef_q} + {new_coef_i[CoefW-1], new_coef_i};
  assign sat    = sum[CoefW] != sum[CoefW-1];
  assign merged = sat ? (sum[CoefW] ? CoefMin : CoefMax) : sum[CoefW-1:0];

  assign flags_o.eq  = exp_q == new_exp_i;
  assign flags_o.gt  = exp_q > new_exp_i;
  assign flags_o.sat = sat;

  always_comb begin
    exp_d  = exp_q;
    coef_d = coef_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        exp_d  = new_exp_i;
        coef_d = new_coef_i;
      end
      CELL_FROM_LEFT: begin
        exp_d  = left_exp_i;
        coef_d = left_coef_i;
      end
      CELL_FROM_RIGHT: begin
        exp_d  = right_exp_i;
        coef_d = right_coef_i;
      end
      CELL_MERGE: begin
        coef_d = merged;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    coef_q <= coef_d;
  end

  assign exp_o  = exp_q;
  assign coef_o = coef_q;

endmodule

// ----- rtl/sorted_sparse_polynomial_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted sparse polynomial table
// Keeps polynomial terms ascending by exponent in a row of cells; adds,
// merges, deletes by position and reads out in the configured order.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     kind, exponent, coefficient, position
// out      output     out_valid_o / out_ready_i   status, out_exponent, out_coefficient,
//                                                 term_count, last
// cfg      input      cfg_we_i                    cfg_data_i (sort order)
//
// An add, delete or unused kind is accepted in S_IDLE; in S_EXEC, once the output
// is free, the cell row compares and shifts as the kind needs. A readout sends its
// terms one at a time through the shared read selector. Reset clears the control
// registers; the cell contents stay undefined and need no clearing pass. A stalled
// result holds in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module sorted_sparse_polynomial_table #(
  parameter int unsigned MAX_TERMS = sspt_pkg::MaxTermsDefault,
  parameter int unsigned EXP_BITS  = sspt_pkg::ExpBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [sspt_pkg::KindW-1:0]             kind_i,
  input  logic [sspt_pkg::ExpW-1:0]              exponent_i,
  input  logic signed [sspt_pkg::CoefW-1:0]      coefficient_i,
  input  logic [sspt_pkg::PosW-1:0]              position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [sspt_pkg::StatusW-1:0]           status_o,
  output logic [sspt_pkg::ExpW-1:0]              out_exponent_o,
  output logic signed [sspt_pkg::CoefW-1:0]      out_coefficient_o,
  output logic [sspt_pkg::TermCountW-1:0]        term_count_o,
  output logic                                   last_o
);
  import sspt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IdxW = $clog2(MAX_TERMS);

  sspt_state_e              state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          rd_k_q, rd_k_d;
  logic                     sort_q;
  logic                     out_valid_q;

  logic [KindW-1:0]         kind_q;
  logic [EXP_BITS-1:0]      exp_q;
  logic signed [CoefW-1:0]  coef_q;
  logic [PosW-1:0]          pos_q;

  logic [StatusW-1:0]       out_status_q, out_status_d;
  logic [ExpW-1:0]          out_exp_q, out_exp_d;
  logic signed [CoefW-1:0]  out_coef_q, out_coef_d;
  logic [TermCountW-1:0]    out_count_q;
  logic                     out_last_q, out_last_d;
  logic                     out_load;
  logic                     out_free;

  logic                     ins_en, merge_en, del_en;
  logic                     match, sat_any, full, pos_ok;
  logic [CntW-1:0]          del_idx;
  logic [CntW-1:0]          rd_idx;

  logic [EXP_BITS-1:0]      cell_exp  [MAX_TERMS];
  logic signed [CoefW-1:0]  cell_coef [MAX_TERMS];
  sspt_cell_flags_t         cell_flags [MAX_TERMS];
  sspt_cell_op_e            cell_op   [MAX_TERMS];
  logic [MAX_TERMS-1:0]     eq_v, gt_v, sat_v, after_v;

  assign in_ready_o = state_q == S_IDLE;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      exp_q  <= EXP_BITS'(exponent_i);
      coef_q <= coefficient_i;
      pos_q  <= position_i;
    end
  end

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic                     occ;
    logic [EXP_BITS-1:0]      left_exp, right_exp;
    logic signed [CoefW-1:0]  left_coef, right_coef;
    logic                     left_after;

    assign occ        = count_q > CntW'(i);
    assign eq_v[i]    = occ && cell_flags[i].eq;
    assign gt_v[i]    = occ && cell_flags[i].gt;
    assign sat_v[i]   = cell_flags[i].sat;
    assign after_v[i] = gt_v[i] || (count_q == CntW'(i));

    if (i == 0) begin : g_first
      assign left_exp   = exp_q;
      assign left_coef  = coef_q;
      assign left_after = 1'b0;
    end else begin : g_inner
      assign left_exp   = cell_exp[i-1];
      assign left_coef  = cell_coef[i-1];
      assign left_after = after_v[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_last
      assign right_exp  = cell_exp[i];
      assign right_coef = cell_coef[i];
    end else begin : g_mid
      assign right_exp  = cell_exp[i+1];
      assign right_coef = cell_coef[i+1];
    end

    always_comb begin
      priority if (merge_en && eq_v[i]) begin
        cell_op[i] = CELL_MERGE;
      end else if (ins_en && left_after) begin
        cell_op[i] = CELL_FROM_LEFT;
      end else if (ins_en && after_v[i]) begin
        cell_op[i] = CELL_LOAD;
      end else if (del_en && (CntW'(i) >= del_idx) && (CntW'(i + 1) < count_q)) begin
        cell_op[i] = CELL_FROM_RIGHT;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    sspt_cell #(
      .EXP_BITS (EXP_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (cell_op[i]),
      .new_exp_i    (exp_q),
      .new_coef_i   (coef_q),
      .left_exp_i   (left_exp),
      .left_coef_i  (left_coef),
      .right_exp_i  (right_exp),
      .right_coef_i (right_coef),
      .exp_o        (cell_exp[i]),
      .coef_o       (cell_coef[i]),
      .flags_o      (cell_flags[i])
    );
  end

  assign match   = |eq_v;
  assign sat_any = |(eq_v & sat_v);
  assign full    = count_q == CntW'(MAX_TERMS);
  assign pos_ok  = TermCountW'(pos_q) < TermCountW'(count_q);
  assign del_idx = sort_q ? CntW'(pos_q) : count_q - CntW'(1) - CntW'(pos_q);
  assign rd_idx  = sort_q ? rd_k_q : count_q - CntW'(1) - rd_k_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_k_d       = rd_k_q;
    out_load     = 1'b0;
    out_status_d = STAT_OK;
    out_exp_d    = '0;
    out_coef_d   = '0;
    out_last_d   = 1'b1;
    ins_en       = 1'b0;
    merge_en     = 1'b0;
    del_en       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          unique case (kind_q)
            KIND_ADD: begin
              out_load = 1'b1;
              if (match) begin
                merge_en     = 1'b1;
                out_status_d = sat_any ? STAT_SAT : STAT_OK;
              end else if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                ins_en  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_DEL: begin
              out_load = 1'b1;
              if (pos_ok) begin
                del_en  = 1'b1;
                count_d = count_q - CntW'(1);
              end else begin
                out_status_d = STAT_RANGE;
              end
            end
            KIND_READ: begin
              if (count_q != '0) begin
                state_d = S_READ;
                rd_k_d  = '0;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_exp_d  = ExpW'(cell_exp[rd_idx[IdxW-1:0]]);
          out_coef_d = cell_coef[rd_idx[IdxW-1:0]];
          out_last_d = (rd_k_q + CntW'(1)) == count_q;
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            rd_k_d = rd_k_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_k_q      <= '0;
      sort_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_k_q      <= rd_k_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (cfg_we_i) begin
        sort_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_exp_q    <= out_exp_d;
      out_coef_q   <= out_coef_d;
      out_count_q  <= TermCountW'(count_d);
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign out_exponent_o    = out_exp_q;
  assign out_coefficient_o = out_coef_q;
  assign term_count_o      = out_count_q;
  assign last_o            = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TERMS))
    else $error("Term count exceeds the table size.");

  a_count_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q == S_EXEC))
    else $error("Term count changed outside the update cycle.");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> (count_q != '0) && (rd_k_q < count_q))
    else $error("Readout index beyond the stored terms.");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted sparse polynomial table
// Drives add, delete, readout and unused-kind items with random idle gaps on
// both channels, predicts every result from a local copy of the term table,
// and checks each result field by field in order. A short directed table
// covers the empty, saturating and out-of-range cases; a fill pass then covers
// the full case, and five random phases run with the term order set per phase.
// ----------------------------------------------------------------------------
module tb_top;
  import sspt_pkg::*;

  localparam int          MaxTerms     = 32;
  localparam int          CycleLimit   = 2000000;
  localparam int          SettleCycles = 40;
  localparam int          DirRows      = 21;
  localparam int          PhaseItems   = 24;
  localparam logic [1:0]  KindUnused   = 2'd3;
  localparam logic        OrderDesc    = 1'b0;
  localparam logic        OrderAsc     = 1'b1;

  typedef struct packed {
    logic         flip;
    logic [1:0]   kind;
    logic [15:0]  exponent;
    logic [31:0]  coefficient;
    logic [5:0]   position;
    logic         typed;
    logic [1:0]   status;
    logic [6:0]   count;
  } stim_row_t;

  typedef struct packed {
    sspt_status_e        status;
    logic [15:0]         exponent;
    logic signed [31:0]  coefficient;
    logic [6:0]          count;
    logic                last;
  } term_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          kind_i;
  logic [15:0]         exponent_i;
  logic signed [31:0]  coefficient_i;
  logic [5:0]          position_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [15:0]         out_exponent_o;
  logic signed [31:0]  out_coefficient_o;
  logic [6:0]          term_count_o;
  logic                last_o;

  logic [15:0]         tbl_exp [MaxTerms];
  logic signed [31:0]  tbl_coef [MaxTerms];
  int                  tbl_count;
  logic                sort_asc;

  term_result_t        pending_results [$];
  term_result_t        front_result;
  stim_row_t           dir_rows [DirRows];
  logic [15:0]         exp_pool [40];
  int                  pool_size;
  bit                  rush;
  int                  ready_hold;
  int                  cycle_count;
  int                  mismatches;
  int                  items_sent;
  int                  results_seen;
  int                  readouts;
  int                  sat_adds;
  int                  full_drops;

  sorted_sparse_polynomial_table u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .exponent_i        (exponent_i),
    .coefficient_i     (coefficient_i),
    .position_i        (position_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .out_exponent_o    (out_exponent_o),
    .out_coefficient_o (out_coefficient_o),
    .term_count_o      (term_count_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (rush) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0h, want %0h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic push_term(input sspt_status_e st, input logic [15:0] ex,
                           input logic signed [31:0] co, input logic fin);
    term_result_t r;
    r.status      = st;
    r.exponent    = ex;
    r.coefficient = co;
    r.count       = 7'(tbl_count);
    r.last        = fin;
    pending_results.push_back(r);
  endtask

  task automatic apply_term_op(input logic [1:0] kind, input logic [15:0] ex,
                               input logic signed [31:0] co, input logic [5:0] pos);
    longint        sum;
    int            at;
    int            idx;
    int            i;
    int            n;
    bit            found;
    sspt_status_e  st;
    st = STAT_OK;
    if (kind == KIND_ADD) begin
      found = 1'b0;
      idx   = 0;
      at    = tbl_count;
      for (i = 0; i < tbl_count; i++) begin
        if (!found && tbl_exp[i] == ex) begin
          found = 1'b1;
          idx   = i;
        end
        if (!found && tbl_exp[i] > ex && at == tbl_count) at = i;
      end
      if (found) begin
        sum = longint'(tbl_coef[idx]) + longint'(co);
        if (sum > longint'(CoefMax)) begin
          sum = longint'(CoefMax);
          st  = STAT_SAT;
        end
        if (sum < longint'(CoefMin)) begin
          sum = longint'(CoefMin);
          st  = STAT_SAT;
        end
        tbl_coef[idx] = sum[31:0];
      end else if (tbl_count >= MaxTerms) begin
        st = STAT_FULL;
      end else begin
        for (i = tbl_count; i > at; i--) begin
          tbl_exp[i]  = tbl_exp[i-1];
          tbl_coef[i] = tbl_coef[i-1];
        end
        tbl_exp[at]  = ex;
        tbl_coef[at] = co;
        tbl_count++;
      end
      if (st == STAT_SAT) sat_adds++;
      if (st == STAT_FULL) full_drops++;
      push_term(st, '0, '0, 1'b1);
    end else if (kind == KIND_DEL) begin
      if (int'(pos) >= tbl_count) begin
        st = STAT_RANGE;
      end else begin
        idx = sort_asc ? int'(pos) : tbl_count - 1 - int'(pos);
        for (i = idx; i + 1 < tbl_count; i++) begin
          tbl_exp[i]  = tbl_exp[i+1];
          tbl_coef[i] = tbl_coef[i+1];
        end
        tbl_count--;
      end
      push_term(st, '0, '0, 1'b1);
    end else if (kind == KIND_READ && tbl_count > 0) begin
      n = tbl_count;
      readouts++;
      for (i = 0; i < n; i++) begin
        idx = sort_asc ? i : n - 1 - i;
        push_term(STAT_OK, tbl_exp[idx], tbl_coef[idx], i + 1 == n);
      end
    end else begin
      if (kind == KIND_READ) readouts++;
      push_term(STAT_OK, '0, '0, 1'b1);
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [15:0] ex,
                           input logic [31:0] co, input logic [5:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    exponent_i    <= ex;
    coefficient_i <= co;
    position_i    <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_term_op(kind, ex, co, pos);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_order(input logic order);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= order;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sort_asc = order;
  endtask

  task automatic random_item();
    int                  r;
    logic [1:0]          kind;
    logic [15:0]         ex;
    logic [31:0]         co;
    logic [5:0]          pos;
    r = $urandom_range(0, 99);
    if (r < 55) kind = KIND_ADD;
    else if (r < 80) kind = KIND_DEL;
    else if (r < 92) kind = KIND_READ;
    else kind = KindUnused;
    if (pool_size > 0) ex = exp_pool[$urandom_range(0, pool_size - 1)];
    else ex = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 10) co = CoefMax;
    else if (r < 20) co = CoefMin;
    else if (r < 50) co = $urandom_range(0, 1) ? 32'($urandom_range(0, 131071))
                                               : -32'($urandom_range(0, 131071));
    else co = $urandom;
    if (tbl_count > 0 && $urandom_range(0, 99) < 80) pos = 6'($urandom_range(0, tbl_count - 1));
    else pos = 6'($urandom_range(0, 63));
    send_item(kind, ex, co, pos);
  endtask

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (rst_ni && !rush && $urandom_range(0, 99) < 25) ready_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", longint'(status_o), 0);
      end else begin
        front_result = pending_results.pop_front();
        if (status_o !== front_result.status)
          report_mismatch("status", status_o, front_result.status);
        if (out_exponent_o !== front_result.exponent)
          report_mismatch("out_exponent", out_exponent_o, front_result.exponent);
        if (out_coefficient_o !== front_result.coefficient)
          report_mismatch("out_coefficient", out_coefficient_o, front_result.coefficient);
        if (term_count_o !== front_result.count)
          report_mismatch("term_count", term_count_o, front_result.count);
        if (last_o !== front_result.last)
          report_mismatch("last", last_o, front_result.last);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0]   co;
    term_result_t  typed_res;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = OrderDesc;
    in_valid_i    = 1'b0;
    kind_i        = KIND_ADD;
    exponent_i    = '0;
    coefficient_i = '0;
    position_i    = '0;
    out_ready_i   = 1'b0;
    tbl_count     = 0;
    sort_asc      = OrderDesc;
    pool_size     = 0;
    rush          = 1'b0;
    ready_hold    = 0;
    cycle_count   = 0;
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    readouts      = 0;
    sat_adds      = 0;
    full_drops    = 0;

    dir_rows = '{
      '{1'b0, KIND_READ,  16'h0000, 32'h0000_0000, 6'd0,  1'b1, STAT_OK,    7'd0},
      '{1'b0, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd0,  1'b1, STAT_RANGE, 7'd0},
      '{1'b0, KindUnused, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, STAT_OK,    7'd0},
      '{1'b0, KIND_ADD,   16'hFFFF, CoefMax,       6'd0,  1'b1, STAT_OK,    7'd1},
      '{1'b0, KIND_ADD,   16'h0000, CoefMin,       6'd0,  1'b1, STAT_OK,    7'd2},
      '{1'b0, KIND_ADD,   16'hFFFF, 32'h0000_0001, 6'd0,  1'b1, STAT_SAT,   7'd2},
      '{1'b0, KIND_ADD,   16'h0000, 32'hFFFF_FFFF, 6'd0,  1'b1, STAT_SAT,   7'd2},
      '{1'b0, KIND_ADD,   16'h8000, 32'h0001_0000, 6'd0,  1'b1, STAT_OK,    7'd3},
      '{1'b0, KIND_ADD,   16'h8000, 32'hFFFF_0000, 6'd0,  1'b1, STAT_OK,    7'd3},
      '{1'b0, KIND_READ,  16'h0000, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,    7'd0},
      '{1'b0, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd63, 1'b1, STAT_RANGE, 7'd3},
      '{1'b0, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd3,  1'b1, STAT_RANGE, 7'd3},
      '{1'b0, KIND_ADD,   16'h00FF, 32'h7FFF_0000, 6'd0,  1'b1, STAT_OK,    7'd4},
      '{1'b0, KIND_ADD,   16'h00FF, 32'h7FFF_0000, 6'd0,  1'b1, STAT_SAT,   7'd4},
      '{1'b0, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd0,  1'b1, STAT_OK,    7'd3},
      '{1'b0, KIND_READ,  16'h0000, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,    7'd0},
      '{1'b0, KindUnused, 16'h0000, 32'h0000_0000, 6'd0,  1'b1, STAT_OK,    7'd3},
      '{1'b1, KIND_READ,  16'h0000, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,    7'd0},
      '{1'b0, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd0,  1'b1, STAT_OK,    7'd2},
      '{1'b0, KIND_READ,  16'h0000, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,    7'd0},
      '{1'b1, KIND_DEL,   16'h0000, 32'h0000_0000, 6'd5,  1'b1, STAT_RANGE, 7'd2}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_order(OrderDesc);

    for (int n = 0; n < DirRows; n++) begin
      if (dir_rows[n].flip) set_order(!sort_asc);
      send_item(dir_rows[n].kind, dir_rows[n].exponent, dir_rows[n].coefficient,
                dir_rows[n].position);
      if (dir_rows[n].typed) begin
        typed_res.status      = sspt_status_e'(dir_rows[n].status);
        typed_res.exponent    = '0;
        typed_res.coefficient = '0;
        typed_res.count       = dir_rows[n].count;
        typed_res.last        = 1'b1;
        pending_results[pending_results.size() - 1] = typed_res;
      end
    end

    // Fill the table to capacity, then try a new exponent and merge an old one.
    while (tbl_count < MaxTerms) begin
      co = $urandom;
      send_item(KIND_ADD, 16'($urandom_range(0, 65535)), co, 6'($urandom_range(0, 63)));
    end
    send_item(KIND_ADD, 16'($urandom_range(0, 65535)), $urandom, '0);
    send_item(KIND_ADD, tbl_exp[$urandom_range(0, MaxTerms - 1)], $urandom, '0);
    send_item(KIND_READ, '0, '0, '0);
    set_order(OrderAsc);
    send_item(KIND_READ, '0, '0, '0);
    send_item(KIND_DEL, '0, '0, 6'd31);

    for (int ph = 0; ph < 5; ph++) begin
      set_order(ph == 4 ? OrderAsc : logic'($urandom_range(0, 1)));
      rush = (ph == 2);
      if (ph == 0) pool_size = 6;
      else if (ph == 1) pool_size = 40;
      else pool_size = 0;
      for (int k = 0; k < 40; k++) exp_pool[k] = 16'($urandom_range(0, 65535));
      exp_pool[0] = 16'h0000;
      exp_pool[1] = 16'hFFFF;
      for (int k = 0; k < PhaseItems; k++) random_item();
    end

    rush = 1'b0;
    drain_results();
    $display("ran %0d items with %0d readouts, %0d saturated adds, %0d adds refused as full",
             items_sent, readouts, sat_adds, full_drops);
    $display("checked %0d results across both term orders, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
